### design/rphc_pkg.sv
// ----------------------------------------------------------------------------
// rphc_pkg
// Shared types and constants for the RPC reply header checker.
// ----------------------------------------------------------------------------
package rphc_pkg;

    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int SKIP_W  = 33;

    // Register indexes (byte address divided by four)
    localparam logic [ADDR_W-3:0] REG_EXPECTED_XID = '0;

    localparam logic [31:0] MSG_TYPE_REPLY   = 32'd1;
    localparam logic [31:0] REPLY_ACCEPTED   = 32'd0;
    localparam logic [31:0] ACCEPT_SUCCESS   = 32'd0;

    typedef enum logic [2:0] {
        PH_XID   = 3'd0,
        PH_TYPE  = 3'd1,
        PH_RSTAT = 3'd2,
        PH_VFLAV = 3'd3,
        PH_VSIZE = 3'd4,
        PH_VSKIP = 3'd5,
        PH_ASTAT = 3'd6,
        PH_DATA  = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TRUNC    = 3'd1,
        ST_XID      = 3'd2,
        ST_NOTREPLY = 3'd3,
        ST_DENIED   = 3'd4,
        ST_ACCEPT   = 3'd5
    } status_t;

    typedef struct packed {
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic              message_done;
        status_t           status;
    } result_t;

endpackage

### design/rpc_reply_header_checker.sv
// ----------------------------------------------------------------------------
// rpc_reply_header_checker
// Checks an ONC RPC reply header byte by byte and passes the payload on.
// Each result is registered in the output buffer, in its skid entry if stalled.
// Throughput: one item per cycle while the skid entry is free; the header state
// update is a single compare-and-shift step per byte, and the skid entry
// absorbs one output stall. Reset: asynchronous, active low; clears the parse
// state, the output buffer and the expected transaction id register.
// ----------------------------------------------------------------------------
module rpc_reply_header_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [rphc_pkg::BYTE_W-1:0] data_byte,
    input  logic                        last_byte,
    // output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        payload_valid,
    output logic [rphc_pkg::BYTE_W-1:0] payload_byte,
    output logic                        message_done,
    output logic [2:0]                  status,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rphc_pkg::ADDR_W-1:0] paddr,
    input  logic [rphc_pkg::DATA_W-1:0] pwdata,
    output logic [rphc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import rphc_pkg::*;

    logic [31:0] match_xid;
    logic        advance;
    logic        buf_full;
    result_t     item_result;
    result_t     out_data;

    // Hold off new items only while the skid entry is occupied
    assign in_stall = buf_full;
    assign advance  = in_valid && !buf_full;

    rphc_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .match_xid (match_xid)
    );

    // Advance the header state on every accepted item; the payload of the
    // item is judged on the state before the update, its end status on the
    // state after it.
    rphc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .match_xid (match_xid),
        .result    (item_result)
    );

    rphc_out_buffer u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .push_data (item_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign payload_valid = out_data.payload_valid;
    assign payload_byte  = out_data.payload_byte;
    assign message_done  = out_data.message_done;
    assign status        = out_data.status;

endmodule

### design/rphc_apb_regs.sv
// ----------------------------------------------------------------------------
// rphc_apb_regs
// APB-style register file holding the expected transaction id.
// ----------------------------------------------------------------------------
module rphc_apb_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rphc_pkg::ADDR_W-1:0] paddr,
    input  logic [rphc_pkg::DATA_W-1:0] pwdata,
    output logic [rphc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output logic [31:0]                match_xid
);
    import rphc_pkg::*;

    logic [31:0] xid_reg;
    logic [31:0] xid_next;
    logic        hit;

    assign pready = 1'b1;
    assign hit    = (paddr[ADDR_W-1:2] == REG_EXPECTED_XID);

    always_comb
    begin
        xid_next = xid_reg;
        if (psel && penable && pwrite && hit)
        begin
            xid_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xid_reg <= '0;
        end
        else
        begin
            xid_reg <= xid_next;
        end
    end

    assign prdata    = hit ? xid_reg : '0;
    assign match_xid = xid_reg;

endmodule

### design/rphc_parser.sv
// ----------------------------------------------------------------------------
// rphc_parser
// Header state machine: word assembly, field checks, verifier skip.
// ----------------------------------------------------------------------------
module rphc_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [rphc_pkg::BYTE_W-1:0] data_byte,
    input  logic                        last_byte,
    input  logic [31:0]                 match_xid,
    output rphc_pkg::result_t           result
);
    import rphc_pkg::*;

    phase_t            phase_reg, phase_next, phase_upd;
    logic [1:0]        biw_reg, biw_next;
    logic [31:0]       word_reg, word_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    status_t           perr_reg, perr_next, perr_upd;

    logic              early;
    logic [SKIP_W-1:0] padded;
    logic [SKIP_W-1:0] skip_dec;

    assign early    = (phase_reg inside {PH_XID, PH_TYPE, PH_RSTAT});
    assign padded   = ({1'b0, word_next} + SKIP_W'(3)) & ~SKIP_W'(3);
    assign skip_dec = skip_reg - SKIP_W'(1);
    assign word_next = {word_reg[23:0], data_byte};

    // Next state
    always_comb
    begin
        phase_upd = phase_reg;
        biw_next  = biw_reg;
        skip_next = skip_reg;
        perr_upd  = perr_reg;
        if (perr_reg != ST_OK && !early)
        begin
            // drop bytes until the end of the message
        end
        else if (phase_reg == PH_VSKIP)
        begin
            skip_next = skip_dec;
            if (skip_dec == '0)
            begin
                phase_upd = PH_ASTAT;
            end
        end
        else if (phase_reg == PH_DATA)
        begin
        end
        else
        begin
            biw_next = biw_reg + 2'd1;
            if (biw_reg == 2'd3)
            begin
                case (phase_reg)
                    PH_XID:
                    begin
                        if (word_next != match_xid && perr_reg == ST_OK)
                            perr_upd = ST_XID;
                        phase_upd = PH_TYPE;
                    end
                    PH_TYPE:
                    begin
                        if (word_next != MSG_TYPE_REPLY && perr_reg == ST_OK)
                            perr_upd = ST_NOTREPLY;
                        phase_upd = PH_RSTAT;
                    end
                    PH_RSTAT:
                    begin
                        if (word_next != REPLY_ACCEPTED && perr_reg == ST_OK)
                            perr_upd = ST_DENIED;
                        phase_upd = PH_VFLAV;
                    end
                    PH_VFLAV:
                    begin
                        phase_upd = PH_VSIZE;
                    end
                    PH_VSIZE:
                    begin
                        skip_next = padded;
                        phase_upd = (padded != '0) ? PH_VSKIP : PH_ASTAT;
                    end
                    default:
                    begin
                        if (word_next != ACCEPT_SUCCESS && perr_reg == ST_OK)
                            perr_upd = ST_ACCEPT;
                        phase_upd = PH_DATA;
                    end
                endcase
            end
        end
        if (last_byte)
        begin
            biw_next  = '0;
            skip_next = '0;
        end
    end

    assign phase_next = last_byte ? PH_XID : phase_upd;
    assign perr_next  = last_byte ? ST_OK : perr_upd;

    // Result for the current item; the status looks at the state after
    // this byte has been taken in
    always_comb
    begin
        result = '{payload_valid: 1'b0, payload_byte: '0, message_done: 1'b0,
                   status: ST_OK};
        if (phase_reg == PH_DATA && perr_reg == ST_OK)
        begin
            result.payload_valid = 1'b1;
            result.payload_byte  = data_byte;
        end
        if (last_byte)
        begin
            result.message_done = 1'b1;
            if (phase_upd inside {PH_XID, PH_TYPE, PH_RSTAT})
                result.status = ST_TRUNC;
            else if (perr_upd != ST_OK)
                result.status = perr_upd;
            else if (phase_upd == PH_DATA)
                result.status = ST_OK;
            else
                result.status = ST_TRUNC;
            if (result.status != ST_OK)
            begin
                result.payload_valid = 1'b0;
                result.payload_byte  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_XID;
            biw_reg   <= '0;
            word_reg  <= '0;
            skip_reg  <= '0;
            perr_reg  <= ST_OK;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            biw_reg   <= biw_next;
            word_reg  <= last_byte ? 32'd0 : word_next;
            skip_reg  <= skip_next;
            perr_reg  <= perr_next;
        end
    end

endmodule

### design/rphc_out_buffer.sv
// ----------------------------------------------------------------------------
// rphc_out_buffer
// Result register with a skid entry, decoupling input and output stalls.
// ----------------------------------------------------------------------------
module rphc_out_buffer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rphc_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output rphc_pkg::result_t out_data
);
    import rphc_pkg::*;

    logic    main_v_reg, main_v_next;
    logic    skid_v_reg, skid_v_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    take;

    assign take = main_v_reg && !out_stall;

    always_comb
    begin
        main_v_next = main_v_reg;
        skid_v_next = skid_v_reg;
        main_next   = main_reg;
        skid_next   = skid_reg;
        if (!main_v_reg || take)
        begin
            if (skid_v_reg)
            begin
                main_next   = skid_reg;
                main_v_next = 1'b1;
                skid_v_next = 1'b0;
            end
            else
            begin
                main_next   = push_data;
                main_v_next = push;
            end
        end
        else if (push)
        begin
            skid_next   = push_data;
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            main_v_reg <= main_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_v_reg;
    assign out_valid = main_v_reg;
    assign out_data  = main_reg;

endmodule

### tb/tb_rpc_reply_header_checker.sv
// ----------------------------------------------------------------------------
// tb_rpc_reply_header_checker
// Self-checking bench for the RPC reply header checker. Streams whole reply
// messages byte by byte (well-formed, corrupted and cut short) and mirrors
// the header parse in a byte-level model. Every result item is checked
// against that model. Runs through several transaction id settings and
// several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_rpc_reply_header_checker;

    timeunit 1ns;
    timeprecision 1ps;

    import rphc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASE_BYTES = 135;
    localparam logic [ADDR_W-1:0] XID_ADDR = {REG_EXPECTED_XID, 2'b00};

    typedef logic [7:0] msg_bytes_t[$];

    // ------------------------------------------------------------------------
    // Byte-level model of the header parse. take_byte() works out the result
    // item of each accepted byte; check_byte_result() compares the oldest
    // outstanding one with what the block produced.
    // ------------------------------------------------------------------------
    class reply_parse_model;
        logic [31:0] xid_reg;
        phase_t      ph;
        logic [1:0]  byte_cnt;
        logic [31:0] word_acc;
        logic [32:0] skip_left;
        status_t     err;
        result_t     byte_results_due[$];
        int unsigned fails;

        function new();
            xid_reg = '0;
            fails   = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            ph        = PH_XID;
            byte_cnt  = '0;
            word_acc  = '0;
            skip_left = '0;
            err       = ST_OK;
        endfunction

        function void set_xid(logic [31:0] v);
            xid_reg = v;
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            result_t r;
            r = '0;
            // Once an error is known past the first three words, ignore bytes.
            if (err == ST_OK || ph < PH_VFLAV) begin
                if (ph == PH_VSKIP) begin
                    skip_left = skip_left - 33'd1;
                    if (skip_left == '0)
                        ph = PH_ASTAT;
                end
                else if (ph == PH_DATA) begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                end
                else begin
                    word_acc = {word_acc[23:0], b};
                    byte_cnt = byte_cnt + 2'd1;
                    if (byte_cnt == 2'd0) begin
                        case (ph)
                            PH_XID:
                            begin
                                if (word_acc != xid_reg && err == ST_OK)
                                    err = ST_XID;
                                ph = PH_TYPE;
                            end
                            PH_TYPE:
                            begin
                                if (word_acc != MSG_TYPE_REPLY && err == ST_OK)
                                    err = ST_NOTREPLY;
                                ph = PH_RSTAT;
                            end
                            PH_RSTAT:
                            begin
                                if (word_acc != REPLY_ACCEPTED && err == ST_OK)
                                    err = ST_DENIED;
                                ph = PH_VFLAV;
                            end
                            PH_VFLAV:
                                ph = PH_VSIZE;
                            PH_VSIZE:
                            begin
                                skip_left = ({1'b0, word_acc} + 33'd3) & ~33'd3;
                                ph = (skip_left != '0) ? PH_VSKIP : PH_ASTAT;
                            end
                            default:
                            begin
                                if (word_acc != ACCEPT_SUCCESS && err == ST_OK)
                                    err = ST_ACCEPT;
                                ph = PH_DATA;
                            end
                        endcase
                    end
                end
            end
            if (last) begin
                r.message_done = 1'b1;
                if (ph < PH_VFLAV)
                    r.status = ST_TRUNC;
                else if (err != ST_OK)
                    r.status = err;
                else if (ph == PH_DATA)
                    r.status = ST_OK;
                else
                    r.status = ST_TRUNC;
                if (r.status != ST_OK) begin
                    r.payload_valid = 1'b0;
                    r.payload_byte  = '0;
                end
                clear_parse();
            end
            byte_results_due.insert(byte_results_due.size(), r);
        endfunction

        function void check_byte_result(result_t got);
            result_t want;
            if (byte_results_due.size() == 0) begin
                $display("%0t: result item with none outstanding: pv=%0b pb=%02h done=%0b st=%0d",
                         $time, got.payload_valid, got.payload_byte,
                         got.message_done, got.status);
                fails++;
                return;
            end
            want = byte_results_due.pop_front();
            if (got.payload_valid !== want.payload_valid) begin
                $display("%0t: payload_valid expected %0b actual %0b",
                         $time, want.payload_valid, got.payload_valid);
                fails++;
            end
            if (got.payload_byte !== want.payload_byte) begin
                $display("%0t: payload_byte expected %02h actual %02h",
                         $time, want.payload_byte, got.payload_byte);
                fails++;
            end
            if (got.message_done !== want.message_done) begin
                $display("%0t: message_done expected %0b actual %0b",
                         $time, want.message_done, got.message_done);
                fails++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                fails++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, block inputs (all known from time zero) and the instance
    // ------------------------------------------------------------------------
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [BYTE_W-1:0]   data_byte = '0;
    logic                last_byte = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                payload_valid;
    logic [BYTE_W-1:0]   payload_byte;
    logic                message_done;
    logic [2:0]          status;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count    = 0;
    int unsigned bytes_sent     = 0;
    logic [31:0] cur_xid        = '0;

    reply_parse_model model = new();

    always #1 clk = ~clk;

    rpc_reply_header_checker i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .message_done  (message_done),
        .status        (status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------------
    // Watchdog: give up well beyond the slowest correct run
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rpc_reply_header_checker: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor both channels at the rising edge. Note the input first, so a
    // result item is never looked up before its byte has been modelled.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall)
            model.take_byte(data_byte, last_byte);
        if (rst_n && out_valid && !out_stall)
            model.check_byte_result(result_t'{payload_valid, payload_byte,
                                              message_done, status_t'(status)});
    end

    // Receiver: stall at random at the rate the current phase asks for
    always @(negedge clk)
        out_stall = ($urandom_range(99) < recv_stall_pct);

    // ------------------------------------------------------------------------
    // Driving tasks; everything changes at the falling edge
    // ------------------------------------------------------------------------

    // Write the transaction id register, then read it back
    task automatic write_xid(input logic [31:0] v);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = XID_ADDR;
        pwdata  = v;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        model.set_xid(v);
        cur_xid = v;
        // Turn straight into the read setup cycle; psel stays high
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== v) begin
            $display("%0t: xid register read back expected %08h actual %08h",
                     $time, v, prdata);
            model.fails++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Offer each byte of a message, holding it until it is taken
    task automatic send_message(input msg_bytes_t msg);
        for (int i = 0; i < msg.size(); i++) begin
            while ($urandom_range(99) < send_idle_pct) begin
                in_valid = 1'b0;
                @(negedge clk);
            end
            in_valid  = 1'b1;
            data_byte = msg[i];
            last_byte = (i == msg.size() - 1);
            do @(posedge clk); while (in_stall);
            bytes_sent++;
            @(negedge clk);
        end
    endtask

    // Drop valid and wait until every result item has come back
    task automatic drain();
        in_valid  = 1'b0;
        last_byte = 1'b0;
        while (model.byte_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic void push_word(ref msg_bytes_t q, input logic [31:0] w);
        q.insert(q.size(), w[31:24]);
        q.insert(q.size(), w[23:16]);
        q.insert(q.size(), w[15:8]);
        q.insert(q.size(), w[7:0]);
    endfunction

    // ------------------------------------------------------------------------
    // Random reply: mostly well-formed with random content; some header
    // fields corrupted, some messages cut short, now and then a verifier
    // size near the top of the range that can only end early.
    // ------------------------------------------------------------------------
    function automatic msg_bytes_t random_message(input logic [31:0] xid);
        msg_bytes_t  q;
        logic [31:0] vsize;
        logic [32:0] padded;
        int unsigned body;
        int unsigned cut;
        bit          huge;
        case ($urandom_range(9))
            0:       push_word(q, ~xid);
            1:       push_word(q, xid ^ (32'd1 << $urandom_range(31)));
            2:       push_word(q, $urandom);
            default: push_word(q, xid);
        endcase
        case ($urandom_range(11))
            0:       push_word(q, 32'd0);
            1:       push_word(q, $urandom);
            default: push_word(q, MSG_TYPE_REPLY);
        endcase
        case ($urandom_range(11))
            0:       push_word(q, 32'd1);
            1:       push_word(q, $urandom);
            default: push_word(q, REPLY_ACCEPTED);
        endcase
        push_word(q, $urandom);
        huge = ($urandom_range(19) == 0);
        vsize = huge ? (32'hFFFF_FFFC | $urandom_range(3)) : $urandom_range(13);
        push_word(q, vsize);
        padded = ({1'b0, vsize} + 33'd3) & ~33'd3;
        body = huge ? $urandom_range(8) : int'(padded);
        repeat (body) q.insert(q.size(), 8'($urandom_range(255)));
        if (!huge) begin
            case ($urandom_range(9))
                0:       push_word(q, 32'd1 << $urandom_range(31));
                1:       push_word(q, $urandom);
                default: push_word(q, ACCEPT_SUCCESS);
            endcase
            repeat ($urandom_range(10)) q.insert(q.size(), 8'($urandom_range(255)));
            // Cut about one message in five short, anywhere
            if ($urandom_range(4) == 0) begin
                cut = $urandom_range(q.size(), 1);
                while (q.size() > cut)
                    void'(q.pop_back());
            end
        end
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        msg_bytes_t m;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, register still at its reset value of zero.
        // A message of one byte ends inside the transaction id word.
        m = {8'hAB};
        send_message(m);
        // Every header word wrong, ending right after the reply status word:
        // the transaction id error must win.
        m = {};
        repeat (3) push_word(m, 32'hFFFF_FFFF);
        send_message(m);
        // Good reply, empty verifier, ending on the last accept status byte
        m = {};
        push_word(m, 32'd0);
        push_word(m, MSG_TYPE_REPLY);
        push_word(m, REPLY_ACCEPTED);
        push_word(m, 32'hFFFF_FFFF);
        push_word(m, 32'd0);
        push_word(m, ACCEPT_SUCCESS);
        send_message(m);
        drain();

        // Random phases: register setting, sender gaps, receiver stalls
        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       begin write_xid(32'hFFFF_FFFF); send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin write_xid($urandom);      send_idle_pct = 61; recv_stall_pct = 0;  end
                2:       begin write_xid(32'd0);         send_idle_pct = 0;  recv_stall_pct = 61; end
                3:       begin write_xid($urandom);      send_idle_pct = 18; recv_stall_pct = 18; end
                default: begin write_xid(32'h8000_0001); send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            bytes_sent = 0;
            while (bytes_sent < ((p == 4) ? PHASE_BYTES / 4 : PHASE_BYTES))
                send_message(random_message(cur_xid));
            drain();
        end

        repeat (10) @(posedge clk);
        if (model.fails == 0 && model.byte_results_due.size() == 0)
            $display("rpc_reply_header_checker: match");
        else
            $display("rpc_reply_header_checker: mismatch");
        $finish;
    end

endmodule

### files.f
design/rphc_pkg.sv
design/rphc_apb_regs.sv
design/rphc_parser.sv
design/rphc_out_buffer.sv
design/rpc_reply_header_checker.sv
tb/tb_rpc_reply_header_checker.sv
